### hdl/pat_pkg.sv
package pat_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_SHIFT_DOWN,
    S_FIND,
    S_RESULT
  } state_t;

endpackage

### hdl/pat_ram.sv
module pat_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/positional_array_table.sv
// Append, remove-last, insert at the end, erase of the last entry, find in an empty table
// and every rejected request go straight to the result state. Other inserts shift the
// words from the position upward up by one, erase shifts the words above the position down
// and find scans from entry 0, one table word per cycle. One request is in work at a time;
// the next is accepted once the result is in the output register.
// Reset clears the entry count and the control state; table words are not cleared.
module positional_array_table
  import pat_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [CNT_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [IDX_W-1:0]         found_index,
  output logic [CNT_W-1:0]         entry_count
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  ptr, ptr_next;
  status_t           res_status, res_status_next;
  logic [IDX_W-1:0]  res_index, res_index_next;
  logic [IDX_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic              load_out;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  count_m1;
  logic              full;

  assign count_m1 = count - CNT_W'(1);
  assign full     = (count == CNT_W'(CAPACITY));
  assign in_ready = (state == S_IDLE);

  pat_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ptr        <= '0;
      res_status <= ST_OK;
      res_index  <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ptr        <= ptr_next;
      res_status <= res_status_next;
      res_index  <= res_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_r <= position[IDX_W-1:0];
      val_r <= value;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_index_next  = res_index;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = ptr;
    mem_wdata       = mem_rdata;
    mem_raddr       = ptr;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_OK;
          res_index_next  = '0;
          state_next      = S_RESULT;
          case (cmd_t'(cmd))
            CMD_APPEND: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = count[IDX_W-1:0];
                mem_wdata  = value;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                count_next = count_m1;
              end
            end
            CMD_INSERT: begin
              if (position > count) begin
                res_status_next = ST_BADPOS;
              end else if (full) begin
                res_status_next = ST_FULL;
              end else if (position == count) begin
                mem_we     = 1'b1;
                mem_waddr  = position[IDX_W-1:0];
                mem_wdata  = value;
                count_next = count + CNT_W'(1);
              end else begin
                // Walk down from the last entry, moving each word up by one.
                mem_raddr  = count_m1[IDX_W-1:0];
                ptr_next   = count_m1[IDX_W-1:0];
                state_next = S_SHIFT_UP;
              end
            end
            CMD_ERASE: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else if (position >= count) begin
                res_status_next = ST_BADPOS;
              end else if (position == count_m1) begin
                count_next = count_m1;
              end else begin
                mem_raddr  = position[IDX_W-1:0] + IDX_W'(1);
                ptr_next   = position[IDX_W-1:0] + IDX_W'(1);
                state_next = S_SHIFT_DOWN;
              end
            end
            CMD_FIND: begin
              if (count == '0) begin
                res_status_next = ST_NOTFOUND;
              end else begin
                mem_raddr  = '0;
                ptr_next   = '0;
                state_next = S_FIND;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // Read data belongs to ptr; writes land above every pending read.
        mem_we    = 1'b1;
        mem_waddr = ptr + IDX_W'(1);
        if (ptr == pos_r) begin
          state_next = S_INS_WRITE;
        end else begin
          mem_raddr = ptr - IDX_W'(1);
          ptr_next  = ptr - IDX_W'(1);
        end
      end

      S_INS_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = pos_r;
        mem_wdata  = val_r;
        count_next = count + CNT_W'(1);
        state_next = S_RESULT;
      end

      S_SHIFT_DOWN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - IDX_W'(1);
        if ({1'b0, ptr} == count_m1) begin
          count_next = count_m1;
          state_next = S_RESULT;
        end else begin
          mem_raddr = ptr + IDX_W'(1);
          ptr_next  = ptr + IDX_W'(1);
        end
      end

      S_FIND: begin
        if (mem_rdata == val_r) begin
          res_index_next = ptr;
          state_next     = S_RESULT;
        end else if ({1'b0, ptr} == count_m1) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESULT;
        end else begin
          mem_raddr = ptr + IDX_W'(1);
          ptr_next  = ptr + IDX_W'(1);
        end
      end

      S_RESULT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      found_index <= res_index;
      entry_count <= count;
    end
  end

endmodule

### hdl/pat_checker.sv
module pat_checker
  import pat_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        status,
  input logic [IDX_W-1:0]         found_index,
  input logic [CNT_W-1:0]         entry_count
);

  // A held result keeps its fields until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_index)
      && $stable(entry_count))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status with a table that is not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty status with a table that is not empty");

  a_index_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_index != '0 |-> status == ST_OK && found_index < entry_count)
    else $error("nonzero index outside a successful find");

endmodule

bind positional_array_table pat_checker u_pat_checker (.*);

### sim/tb.sv
module tb;
  import pat_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } table_result_t;

  localparam int MAX_REPORTS = 40;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         cmd = '0;
  logic [CNT_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STAT_W-1:0]        status;
  logic [IDX_W-1:0]         found_index;
  logic [CNT_W-1:0]         entry_count;

  // Shadow copy of the table, updated when a request is accepted.
  logic [DATA_W-1:0] shadow_words[CAPACITY];
  int                shadow_count = 0;

  table_result_t pending_results[$];
  int            error_count = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;

  positional_array_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .position    (position),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic table_result_t apply_request(input logic [CMD_W-1:0] c,
                                                  input logic [CNT_W-1:0] p,
                                                  input logic [DATA_W-1:0] v);
    table_result_t r;
    r.status = ST_OK;
    r.idx = '0;
    case (c)
      CMD_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = v;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      CMD_INSERT: begin
        // The position check takes priority over the full check.
        if (p > shadow_count) begin
          r.status = ST_BADPOS;
        end else if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = v;
          shadow_count++;
        end
      end
      CMD_ERASE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] === v) begin
            r.status = ST_OK;
            r.idx = IDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", status, 0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (found_index !== want.idx) report_mismatch("found_index", found_index, want.idx);
        if (entry_count !== want.count) report_mismatch("entry_count", entry_count, want.count);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [CNT_W-1:0] p,
                              input logic [DATA_W-1:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    position <= p;
    value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), apply_request(c, p, v));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input bit for_find);
    logic [DATA_W-1:0] corners[6] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0005};
    int k;
    k = $urandom_range(9);
    if (for_find && shadow_count > 0 && k < 5)
      return shadow_words[$urandom_range(shadow_count - 1)];
    if (k < 3) return corners[$urandom_range(5)];
    return $urandom;
  endfunction

  task automatic random_request(input int grow_pct);
    int               r;
    logic [CMD_W-1:0] c;
    logic [CNT_W-1:0] p;
    r = $urandom_range(99);
    if (r < 4) c = CMD_W'($urandom_range(2**CMD_W - 1, CMD_FIND + 1));
    else if (r < 24) c = CMD_FIND;
    else if ($urandom_range(99) < grow_pct) c = $urandom_range(1) ? CMD_INSERT : CMD_APPEND;
    else c = $urandom_range(1) ? CMD_ERASE : CMD_REMOVE;
    if ($urandom_range(99) < 12) p = CNT_W'($urandom);
    else if (c == CMD_ERASE && shadow_count > 0) p = CNT_W'($urandom_range(shadow_count - 1));
    else p = CNT_W'($urandom_range(shadow_count));
    send_request(c, p, pick_value(c == CMD_FIND));
  endtask

  task automatic test_empty_table();
    send_request(CMD_FIND, 0, 32'h0000_0000);
    send_request(CMD_REMOVE, 0, 32'h0000_0000);
    send_request(CMD_ERASE, 0, 32'h0000_0000);
    send_request(CMD_ERASE, '1, 32'hffff_ffff);
    send_request(CMD_INSERT, 1, 32'h1234_5678);
    send_request(CMD_INSERT, '1, 32'h1234_5678);
    for (int c = CMD_FIND + 1; c < 2**CMD_W; c++) send_request(CMD_W'(c), '1, 32'hffff_ffff);
  endtask

  task automatic test_edit_ops();
    send_request(CMD_INSERT, 0, 32'h7fff_ffff);
    send_request(CMD_APPEND, '1, 32'h8000_0000);
    send_request(CMD_INSERT, 1, 32'hffff_ffff);
    send_request(CMD_APPEND, 0, 32'h0000_0000);
    send_request(CMD_INSERT, CNT_W'(shadow_count), 32'h0000_0042);
    send_request(CMD_FIND, 0, 32'h7fff_ffff);
    send_request(CMD_FIND, 0, 32'h8000_0000);
    send_request(CMD_FIND, 0, 32'h0001_2345);
    // A duplicate at the end; find must still report the earlier copy.
    send_request(CMD_APPEND, 0, 32'hffff_ffff);
    send_request(CMD_FIND, '1, 32'hffff_ffff);
    send_request(CMD_ERASE, CNT_W'(shadow_count), 32'h0000_0000);
    send_request(CMD_ERASE, 1, 32'h0000_0000);
    send_request(CMD_ERASE, CNT_W'(shadow_count - 1), 32'h0000_0000);
    send_request(CMD_REMOVE, 0, 32'h0000_0000);
  endtask

  task automatic test_full_table();
    while (shadow_count < CAPACITY) send_request(CMD_APPEND, CNT_W'($urandom), $urandom);
    send_request(CMD_APPEND, 0, 32'h0000_0000);
    send_request(CMD_INSERT, 0, 32'h0000_0000);
    send_request(CMD_INSERT, CNT_W'(CAPACITY), 32'h0000_0000);
    send_request(CMD_INSERT, CNT_W'(CAPACITY + 1), 32'h0000_0000);
    send_request(CMD_INSERT, '1, 32'h0000_0000);
    send_request(CMD_FIND, 0, shadow_words[CAPACITY - 1]);
    send_request(CMD_ERASE, CNT_W'(CAPACITY), 32'h0000_0000);
    send_request(CMD_ERASE, CNT_W'(CAPACITY - 1), 32'h0000_0000);
    send_request(CMD_APPEND, 0, 32'h5a5a_a5a5);
    send_request(CMD_ERASE, 0, 32'h0000_0000);
    send_request(CMD_INSERT, 0, 32'ha5a5_5a5a);
    send_request(CMD_FIND, 0, 32'ha5a5_5a5a);
    // Drain with a mix of the two shrinking commands, erases at 0 taking the long path until one entry is left.
    while (shadow_count > 0) begin
      if ($urandom_range(1)) send_request(CMD_ERASE, 0, $urandom);
      else send_request(CMD_REMOVE, CNT_W'($urandom), $urandom);
    end
    send_request(CMD_REMOVE, 0, 32'h0000_0000);
  endtask

  task automatic test_random(input int send_pct, input int stall_pct, input int n);
    set_idling(send_pct, stall_pct);
    for (int i = 0; i < n; i++) random_request((i / 50) % 2 == 0 ? 75 : 30);
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_idling(0, 0);
    test_empty_table();
    test_edit_ops();
    wait_drained();
    set_idling(32, 32);
    test_full_table();
    wait_drained();
    test_random(0, 0, 160);
    test_random(81, 0, 160);
    test_random(0, 81, 160);
    test_random(32, 32, 160);

    repeat (CAPACITY + 8) @(posedge clk);
    if (error_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
